// ----- sv/aesk_pkg.sv -----
package aesk_pkg;

	localparam int unsigned KEY_W    = 128;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned ROUND_W  = 4;
	localparam int unsigned IN_DATA_W  = 136;
	localparam int unsigned OUT_DATA_W = 128;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	typedef logic [WORD_W-1:0] word_t;

	function automatic logic [7:0] rcon(input logic [ROUND_W-1:0] round_number);
		logic [7:0] r;
		case (round_number)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// ----- sv/aesk_sbox_lane.sv -----
module aesk_sbox_lane (
	input  logic       clk,
	input  logic       en,
	input  logic [7:0] din,
	output logic [7:0] dout
);
	import aesk_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= SBOX[din];
		end
	end

endmodule

// ----- sv/aesk_merge.sv -----
module aesk_merge (
	input  logic          clk,
	input  logic          en,
	input  aesk_pkg::word_t sub_word,
	input  logic [7:0]    rcon_byte,
	input  aesk_pkg::word_t w0,
	input  aesk_pkg::word_t w1,
	input  aesk_pkg::word_t w2,
	input  aesk_pkg::word_t w3,
	output logic [aesk_pkg::KEY_W-1:0] next_key
);
	import aesk_pkg::*;

	word_t t, n0, n1, n2, n3;

	always_comb begin
		t  = sub_word ^ {rcon_byte, 24'h000000};
		n0 = w0 ^ t;
		n1 = w1 ^ n0;
		n2 = w2 ^ n1;
		n3 = w3 ^ n2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			next_key <= {n0, n1, n2, n3};
		end
	end

endmodule

// ----- sv/aes128_round_key_next_core.sv -----
// channel  | direction | fields (lowest bit up)
// s_axis   | in        | key_high[63:0], key_low[127:64], round_number[131:128], zero pad
// m_axis   | out       | next_high[63:0], next_low[127:64]
//
// Two-stage pipeline: four S-box lanes register the substituted word, then the
// merge stage registers the chained XOR result. One item per cycle sustained
// while m_axis_tready stays high; tvalid rises once the item has passed the
// stage-one and stage-two valid registers.
// arst_n clears the stage valid flags only.
// A stalled output holds stage two, and stage one once it is full; input stays
// ready while stage one can move.
module aes128_round_key_next_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [135:0] s_axis_tdata,  // key_high, key_low, round_number, pad
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // next_high, next_low
);
	import aesk_pkg::*;

	logic [63:0]        key_high, key_low;
	logic [ROUND_W-1:0] round_number;
	word_t              w3_in, rot;
	word_t              w0_s1, w1_s1, w2_s1, w3_s1, sub_s1;
	logic [7:0]         rcon_s1;
	logic               v_s1, v_s2;
	logic               en_s1, en_s2;
	logic [KEY_W-1:0]   next_key;

	assign key_high     = s_axis_tdata[63:0];
	assign key_low      = s_axis_tdata[127:64];
	assign round_number = s_axis_tdata[131:128];
	assign w3_in        = key_low[31:0];
	assign rot          = {w3_in[23:0], w3_in[31:24]};

	assign en_s2         = !v_s2 || m_axis_tready;
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1;

	genvar i;
	generate
		for (i = 0; i < 4; i++) begin : g_lane
			aesk_sbox_lane u_lane (
				.clk  (clk),
				.en   (en_s1),
				.din  (rot[8*i +: 8]),
				.dout (sub_s1[8*i +: 8])
			);
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (en_s1) begin
			w0_s1   <= key_high[63:32];
			w1_s1   <= key_high[31:0];
			w2_s1   <= key_low[63:32];
			w3_s1   <= w3_in;
			rcon_s1 <= rcon(round_number);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	aesk_merge u_merge (
		.clk       (clk),
		.en        (en_s2),
		.sub_word  (sub_s1),
		.rcon_byte (rcon_s1),
		.w0        (w0_s1),
		.w1        (w1_s1),
		.w2        (w2_s1),
		.w3        (w3_s1),
		.next_key  (next_key)
	);

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = {next_key[63:0], next_key[127:64]};

endmodule

// ----- tb/aes128_round_key_next_core_tb.sv -----
`timescale 1ns / 1ps

module aes128_round_key_next_core_tb;

	localparam int unsigned CLK_HALF   = 6;
	localparam int unsigned RESET_CYC  = 10;
	localparam int unsigned RAND_ITEMS = 1150;
	localparam int unsigned IDLE_LIMIT = 2000;
	localparam int unsigned DRAIN_CYC  = 8;
	localparam int unsigned DIR_ROWS   = 21;
	localparam logic [3:0]  LAST_ROUND = 4'd10;

	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
	} key_pair_t;

	typedef struct packed {
		logic [63:0] kh;
		logic [63:0] kl;
		logic [3:0]  rn;
		bit          typed;
		logic [63:0] eh;
		logic [63:0] el;
	} step_row_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            s_axis_tvalid = 1'b0;
	logic                            s_axis_tready;
	logic [aesk_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready = 1'b0;
	logic [aesk_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	logic [7:0] sub_lut [256];
	key_pair_t  next_key_q [$];
	int         mismatch_cnt = 0;
	int         idle_cnt     = 0;
	bit         quiet        = 1'b0;

	const step_row_t dir_rows [DIR_ROWS] = '{
		'{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 4'd1, 1'b1,
			64'ha0fafe1788542cb1, 64'h23a339392a6c7605},
		'{64'ha0fafe1788542cb1, 64'h23a339392a6c7605, 4'd2, 1'b1,
			64'hf2c295f27a96b943, 64'h5935807a7359f67f},
		'{64'hf2c295f27a96b943, 64'h5935807a7359f67f, 4'd3, 1'b1,
			64'h3d80477d4716fe3e, 64'h1e237e446d7a883b},
		'{64'h0000000000000000, 64'h0000000000000000, 4'd1, 1'b1,
			64'h6263636362636363, 64'h6263636362636363},
		'{64'h6263636362636363, 64'h6263636362636363, 4'd2, 1'b1,
			64'h9b9898c9f9fbfbaa, 64'h9b9898c9f9fbfbaa},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 4'd1, 1'b1,
			64'he8e9e9e917161616, 64'he8e9e9e917161616},
		'{64'h0000000000000000, 64'h0000000000000000, 4'd0, 1'b1,
			64'h6363636363636363, 64'h6363636363636363},
		'{64'h0000000000000000, 64'h0000000000000000, 4'd15, 1'b1,
			64'h6363636363636363, 64'h6363636363636363},
		'{64'h0123456789abcdef, 64'hfedcba9876543210, 4'd4, 1'b0, '0, '0},
		'{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 4'd5, 1'b0, '0, '0},
		'{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 4'd6, 1'b0, '0, '0},
		'{64'h8000000000000001, 64'h8000000000000001, 4'd7, 1'b0, '0, '0},
		'{64'h00000000ffffffff, 64'hffffffff00000000, 4'd8, 1'b0, '0, '0},
		'{64'hdeadbeefcafef00d, 64'h0f1e2d3c4b5a6978, 4'd9, 1'b0, '0, '0},
		'{64'hffffffffffffffff, 64'hffffffffffffffff, 4'd10, 1'b0, '0, '0},
		'{64'h0000000000000000, 64'h0000000000000000, 4'd10, 1'b0, '0, '0},
		'{64'h1122334455667788, 64'h99aabbccddeeff00, 4'd11, 1'b0, '0, '0},
		'{64'h7f7f7f7f7f7f7f7f, 64'h8080808080808080, 4'd12, 1'b0, '0, '0},
		'{64'h0102040810204080, 64'hfefdfbf7efdfbf7f, 4'd13, 1'b0, '0, '0},
		'{64'hffffffffffffffff, 64'h0000000000000000, 4'd14, 1'b0, '0, '0},
		'{64'h0000000000000000, 64'hffffffffffffffff, 4'd9, 1'b0, '0, '0}
	};

	aes128_round_key_next_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),  // key_high, key_low, round_number, pad
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)   // next_high, next_low
	);

	always #CLK_HALF clk = ~clk;

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		logic [7:0] x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p ^= x;
			end
			x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
		end
		return p;
	endfunction

	// multiplicative inverse as b^254, then the affine map
	function automatic logic [7:0] subst_byte(input logic [7:0] b);
		logic [7:0] inv;
		inv = 8'h01;
		for (int i = 0; i < 254; i++) begin
			inv = gf_mul(inv, b);
		end
		return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
			^ {inv[3:0], inv[7:4]} ^ 8'h63;
	endfunction

	function automatic logic [7:0] round_const(input logic [3:0] rn);
		logic [7:0] c;
		c = 8'h01;
		if (rn == 4'd0 || rn > LAST_ROUND) begin
			return 8'h00;
		end
		for (int i = 1; i < int'(rn); i++) begin
			c = gf_mul(c, 8'h02);
		end
		return c;
	endfunction

	function automatic key_pair_t expand_round(input logic [63:0] kh, input logic [63:0] kl,
			input logic [3:0] rn);
		logic [31:0] rot;
		logic [31:0] t;
		logic [31:0] n0;
		logic [31:0] n1;
		logic [31:0] n2;
		logic [31:0] n3;
		key_pair_t   r;
		rot = {kl[23:0], kl[31:24]};
		t   = {sub_lut[rot[31:24]], sub_lut[rot[23:16]], sub_lut[rot[15:8]], sub_lut[rot[7:0]]}
			^ {round_const(rn), 24'h000000};
		n0  = kh[63:32] ^ t;
		n1  = kh[31:0] ^ n0;
		n2  = kl[63:32] ^ n1;
		n3  = kl[31:0] ^ n2;
		r.hi = {n0, n1};
		r.lo = {n2, n3};
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [63:0] rand_half();
		logic [63:0] v;
		int          r;
		v = {$urandom, $urandom};
		r = $urandom_range(0, 15);
		case (r)
			0:       v = '0;
			1:       v = '1;
			2:       v = v & (64'hff << (8 * $urandom_range(0, 7)));
			3:       v = v | ~(64'hff << (8 * $urandom_range(0, 7)));
			default: ;
		endcase
		return v;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
		mismatch_cnt++;
	endtask

	task automatic drive_key(input logic [63:0] kh, input logic [63:0] kl,
			input logic [3:0] rn, input key_pair_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'h0, rn, kl, kh};
		do @(posedge clk); while (!s_axis_tready);
		next_key_q.push_back(want);
	endtask

	always @(posedge clk) begin
		key_pair_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (next_key_q.size() == 0) begin
				flag_mismatch("unexpected next_high", m_axis_tdata[63:0], '0);
			end else begin
				want = next_key_q.pop_front();
				if (m_axis_tdata[63:0] !== want.hi) begin
					flag_mismatch("next_high", m_axis_tdata[63:0], want.hi);
				end
				if (m_axis_tdata[127:64] !== want.lo) begin
					flag_mismatch("next_low", m_axis_tdata[127:64], want.lo);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cnt <= 0;
		end else if (idle_cnt >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", idle_cnt);
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
	end

	initial begin
		int run;
		int stall;
		forever begin
			run = quiet ? 20 : $urandom_range(1, 12);
			m_axis_tready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	initial begin
		int          sent;
		logic [63:0] kh;
		logic [63:0] kl;
		logic [3:0]  rn;
		key_pair_t   want;
		for (int b = 0; b < 256; b++) begin
			sub_lut[b] = subst_byte(8'(b));
		end
		repeat (RESET_CYC) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].typed) begin
				want.hi = dir_rows[i].eh;
				want.lo = dir_rows[i].el;
			end else begin
				want = expand_round(dir_rows[i].kh, dir_rows[i].kl, dir_rows[i].rn);
			end
			drive_key(dir_rows[i].kh, dir_rows[i].kl, dir_rows[i].rn, want);
		end

		sent = 0;
		while (sent < RAND_ITEMS) begin
			if (sent % 100 < 10) begin
				quiet = ($urandom_range(0, 3) == 0);
			end
			kh = rand_half();
			kl = rand_half();
			if ($urandom_range(0, 9) < 7) begin
				// walk a full schedule, feeding each round key back in
				for (int r = 1; r <= int'(LAST_ROUND); r++) begin
					want = expand_round(kh, kl, 4'(r));
					drive_key(kh, kl, 4'(r), want);
					kh = want.hi;
					kl = want.lo;
				end
				sent += int'(LAST_ROUND);
			end else begin
				rn = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 10));
				want = expand_round(kh, kl, rn);
				drive_key(kh, kl, rn, want);
				sent++;
			end
		end
		s_axis_tvalid <= 1'b0;

		while (next_key_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
